### rtl/core/tfbs_pkg.sv
// Shared types and constants for the typed field byte serializer.
// No dependencies; every file of the block but tfbs_if imports it.
package tfbs_pkg;

  localparam int unsigned MaxJobBytes  = 6;
  localparam int unsigned JobCountW    = 3;
  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [2:0] {
    OpBool  = 3'd0,
    OpByte  = 3'd1,
    OpShort = 3'd2,
    OpInt   = 3'd3,
    OpVarint = 3'd4,
    OpFlush = 3'd5
  } opcode_e;

  // One queued transaction for the back end: bytes in stream order.
  typedef struct packed {
    logic [MaxJobBytes-1:0][7:0] bytes;
    logic [JobCountW-1:0]        count;
  } job_t;

endpackage

### rtl/core/tfbs_if.sv
// Valid/ready channel interfaces for the serializer's input and output.
// Depends on nothing but the port naming convention of the block.
interface tfbs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] field_value;

  modport source (output valid, output opcode, output field_value, input ready);
  modport sink   (input valid, input opcode, input field_value, output ready);
endinterface

interface tfbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### rtl/core/tfbs_front.sv
// Front end: accepts requests, packs booleans and builds byte jobs.
// Depends on tfbs_pkg.
module tfbs_front import tfbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] field_value_i,
  output logic               ready_o,
  input  logic               full_i,
  output logic               push_o,
  output job_t               job_o
);

  localparam logic [31:0] PosLim1 = 32'h0000_0040;
  localparam logic [31:0] PosLim2 = 32'h0000_2000;
  localparam logic [31:0] PosLim3 = 32'h0010_0000;
  localparam logic [31:0] PosLim4 = 32'h0800_0000;
  localparam logic [31:0] NegLim1 = 32'hFFFF_FFC0;
  localparam logic [31:0] NegLim2 = 32'hFFFF_E000;
  localparam logic [31:0] NegLim3 = 32'hFFF0_0000;
  localparam logic [31:0] NegLim4 = 32'hF800_0000;

  logic [7:0] bits_q, bits_d;
  logic [2:0] pos_q, pos_d;
  logic       pend_q, pend_d;

  logic        accept;
  logic [31:0] u;
  logic        neg;
  logic [2:0]  vlen;
  logic [4:0][7:0] fb;
  logic [2:0]  fcnt;
  logic [7:0]  bbits;
  logic [2:0]  bpos;
  job_t        job;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign u       = field_value_i;
  assign neg     = u[31];

  always_comb begin
    if (!neg) begin
      if (u < PosLim1)      vlen = 3'd1;
      else if (u < PosLim2) vlen = 3'd2;
      else if (u < PosLim3) vlen = 3'd3;
      else if (u < PosLim4) vlen = 3'd4;
      else                  vlen = 3'd5;
    end else begin
      if (u > NegLim1)      vlen = 3'd1;
      else if (u > NegLim2) vlen = 3'd2;
      else if (u > NegLim3) vlen = 3'd3;
      else if (u > NegLim4) vlen = 3'd4;
      else                  vlen = 3'd5;
    end
  end

  // Field bytes of the request, without any pending boolean byte.
  always_comb begin
    fb   = '0;
    fcnt = 3'd0;
    unique case (opcode_i)
      OpByte: begin
        fb[0] = u[7:0];
        fcnt  = 3'd1;
      end
      OpShort: begin
        fb[0] = u[15:8];
        fb[1] = u[7:0];
        fcnt  = 3'd2;
      end
      OpInt: begin
        fb[0] = u[31:24];
        fb[1] = u[23:16];
        fb[2] = u[15:8];
        fb[3] = u[7:0];
        fcnt  = 3'd4;
      end
      OpVarint: begin
        fb[0] = {vlen > 3'd1, neg, u[5:0]};
        fb[1] = {vlen > 3'd2, u[12:6]};
        fb[2] = {vlen > 3'd3, u[19:13]};
        fb[3] = {vlen > 3'd4, u[26:20]};
        fb[4] = {4'b0000, u[30:27]};
        fcnt  = vlen;
      end
      default: begin
        fb   = '0;
        fcnt = 3'd0;
      end
    endcase
  end

  always_comb begin
    job    = '0;
    bits_d = bits_q;
    pos_d  = pos_q;
    pend_d = pend_q;
    bbits  = pend_q ? bits_q : 8'h00;
    bpos   = pend_q ? pos_q : 3'd0;
    if (field_value_i[0]) bbits = bbits | (8'h01 << bpos);
    unique case (opcode_i) inside
      OpBool: begin
        if (bpos == 3'd7) begin
          job.bytes[0] = bbits;
          job.count    = 3'd1;
          bits_d = 8'h00;
          pos_d  = 3'd0;
          pend_d = 1'b0;
        end else begin
          bits_d = bbits;
          pos_d  = bpos + 3'd1;
          pend_d = 1'b1;
        end
      end
      OpByte, OpShort, OpInt, OpVarint, OpFlush: begin
        if (pend_q) begin
          job.bytes[0] = bits_q;
          for (int i = 1; i < MaxJobBytes; i++) job.bytes[i] = fb[i-1];
          job.count = fcnt + 3'd1;
        end else begin
          for (int i = 0; i < MaxJobBytes - 1; i++) job.bytes[i] = fb[i];
          job.count = fcnt;
        end
        bits_d = 8'h00;
        pos_d  = 3'd0;
        pend_d = 1'b0;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  assign job_o  = job;
  assign push_o = accept && (job.count != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= 8'h00;
      pos_q  <= 3'd0;
      pend_q <= 1'b0;
    end else if (accept) begin
      bits_q <= bits_d;
      pos_q  <= pos_d;
      pend_q <= pend_d;
    end
  end

endmodule

### rtl/core/tfbs_queue.sv
// Small register FIFO of byte jobs between front and back end.
// Depends on tfbs_pkg for the job type.
module tfbs_queue import tfbs_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

### rtl/core/tfbs_back.sv
// Back end: walks a job out a byte per unstalled cycle, registered.
// Depends on tfbs_pkg for the job type.
module tfbs_back import tfbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  job_t                 cur_q;
  logic [JobCountW-1:0] idx_q;
  logic                 busy_q;
  logic                 valid_q;
  logic [7:0]           byte_q;
  logic                 last_q;

  logic load_out;
  logic is_last;

  assign load_out = !valid_q || ready_i;
  assign is_last  = (idx_q == cur_q.count - JobCountW'(1));
  // Refill the job slot when empty or while its final byte moves out.
  assign pop_o    = !empty_i && (!busy_q || (load_out && is_last));

  always_ff @(posedge clk_i) begin
    if (load_out && busy_q) begin
      byte_q <= cur_q.bytes[idx_q];
      last_q <= is_last;
    end
    if (pop_o) cur_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load_out) valid_q <= busy_q;
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load_out && busy_q) begin
        if (is_last) busy_q <= 1'b0;
        idx_q <= idx_q + JobCountW'(1);
      end
    end
  end

  assign valid_o    = valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

endmodule

### rtl/core/typed_field_byte_serializer.sv
// Typed field byte serializer top level: front end, job queue, back end.
// Depends on tfbs_pkg, tfbs_if, tfbs_front, tfbs_queue and tfbs_back.

// Each request (boolean, byte, short, int, signed varint, flush) is turned
// into a job of 0 to 6 bytes; the stream leaves one byte per cycle while the
// output is ready, with the byte-wide output register as the limit. Requests
// that produce nothing (booleans short of a full byte, empty flushes, unused
// opcodes) push no job. A queue of QueueDepth jobs lets the front keep
// accepting while the back drains; an accepted job passes through the queue,
// the back end's job slot and output register before its first byte leaves.
module typed_field_byte_serializer import tfbs_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tfbs_in_if.sink    in_i,
  tfbs_out_if.source out_o
);

  job_t front_job, queue_job;
  logic push, pop, full, empty;

  tfbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .opcode_i      (in_i.opcode),
    .field_value_i (in_i.field_value),
    .ready_o       (in_i.ready),
    .full_i        (full),
    .push_o        (push),
    .job_o         (front_job)
  );

  tfbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (queue_job),
    .full_o  (full),
    .empty_o (empty)
  );

  tfbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (queue_job),
    .empty_i    (empty),
    .pop_o      (pop),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .out_byte_o (out_o.out_byte),
    .last_o     (out_o.last)
  );

endmodule
